### rtl/core/spa_pkg.sv
// Shared constants for the spectrum power averager core.
// No dependencies; imported by spectrum_power_averager_core.
package spa_pkg;

    // Default sizing
    localparam int NUM_BINS_DEF    = 1024;
    localparam int SAMPLE_BITS_DEF = 24;

    // Fixed field widths
    localparam int IDX_W   = 10;
    localparam int PWR_W   = 48;
    localparam int FRAME_W = 16;
    localparam int SHIFT_W = 6;

    localparam logic [PWR_W-1:0]   PWR_MAX   = '1;
    localparam logic [FRAME_W-1:0] FRAME_MAX = '1;
    localparam logic [SHIFT_W-1:0] SHIFT_RST = SHIFT_W'(20);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_HOLD   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_SHIFT = CFG_IDX_W'(1);

endpackage

### rtl/core/spectrum_power_averager_core.sv
// Spectrum power averager core: per-bin power, running mean or peak hold.
// Depends on spa_pkg (widths, register indexes, defaults).
//
// Usage:
//   in channel (in_valid/in_ready) takes one transform bin per item:
//   bin_re, bin_im, bin_index, last_bin. out channel (out_valid/out_ready)
//   returns one item per input: out_index, avg_power, frame_number, out_last.
//   cfg channel (cfg_valid/cfg_ready) writes peak_hold (index 0) and
//   scale_shift (index 1); cfg_ready is always high.
// Operation:
//   One item at a time. A bit-serial shift-add squarer runs while the bin
//   slot is reduced one index bit a cycle; then the store is read, the
//   power computed and the result written. Running mean after the first
//   frame adds a 48-step restoring divider and an apply step; first frame
//   and peak hold skip them.
// Reset:
//   Frame count goes to one, registers to their defaults, and the power
//   store is cleared one entry a cycle across all NUM_BINS entries; in_ready
//   stays low during that pass.
// Stall:
//   A finished item sits in the output register; the next input item is
//   accepted meanwhile, and its result waits until the register is free.
module spectrum_power_averager_core
    import spa_pkg::*;
#(
    parameter int NUM_BINS    = NUM_BINS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] bin_re,
    input  logic signed [SAMPLE_BITS-1:0] bin_im,
    input  logic [IDX_W-1:0]              bin_index,
    input  logic                          last_bin,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [IDX_W-1:0]              out_index,
    output logic [PWR_W-1:0]              avg_power,
    output logic [FRAME_W-1:0]            frame_number,
    output logic                          out_last
);

    localparam int AW      = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int PW      = 2 * SAMPLE_BITS;
    localparam int EXT_W   = (PW > PWR_W) ? PW : PWR_W;
    localparam int MUL_CYC = (SAMPLE_BITS > IDX_W) ? SAMPLE_BITS : IDX_W;
    localparam int MAX_CYC = (MUL_CYC > PWR_W) ? MUL_CYC : PWR_W;
    localparam int CNT_W   = $clog2(MAX_CYC + 1);

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_MUL   = 8'b0000_0100,
        ST_READ  = 8'b0000_1000,
        ST_CALC  = 8'b0001_0000,
        ST_DIV   = 8'b0010_0000,
        ST_APPLY = 8'b0100_0000,
        ST_WRITE = 8'b1000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [AW-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [FRAME_W-1:0]   frame_count_reg, frame_count_next;
    logic                 peak_hold_reg, peak_hold_next;
    logic [SHIFT_W-1:0]   shift_reg, shift_next;
    logic                 out_valid_reg, out_valid_next;

    // Datapath registers
    logic [SAMPLE_BITS-1:0] a_bits_reg, b_bits_reg;
    logic [PW-1:0]          a_mul_reg, b_mul_reg, acc_reg;
    logic [IDX_W-1:0]       idx_sh_reg, index_reg;
    logic                   last_reg;
    logic [AW-1:0]          slot_reg;
    logic [PWR_W-1:0]       p_reg, old_reg, q_reg, nv_reg;
    logic [FRAME_W-1:0]     rem_reg;
    logic                   neg_reg;
    logic [IDX_W-1:0]       out_index_reg;
    logic [PWR_W-1:0]       out_power_reg;
    logic [FRAME_W-1:0]     out_frame_reg;
    logic                   out_last_reg;

    logic [PWR_W-1:0]       mem [NUM_BINS];

    logic                   in_accept, out_free, out_load;
    logic [SAMPLE_BITS-1:0] mag_re, mag_im;
    logic [PW-1:0]          acc_sum, p_sh;
    logic [EXT_W-1:0]       p_ext;
    logic [PWR_W-1:0]       p_sat, diff_mag;
    logic [AW:0]            mod_trial;
    logic [AW-1:0]          mod_next;
    logic [FRAME_W:0]       div_trial;
    logic                   div_bit;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [PWR_W-1:0]       mem_wdata;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = (state_reg == ST_WRITE) && out_free;

    // Sample magnitudes (most negative value maps to 2^(SAMPLE_BITS-1))
    assign mag_re = bin_re[SAMPLE_BITS-1] ? (~bin_re + 1'b1) : bin_re;
    assign mag_im = bin_im[SAMPLE_BITS-1] ? (~bin_im + 1'b1) : bin_im;

    // Shift-add squarer step
    assign acc_sum = acc_reg + (a_bits_reg[0] ? a_mul_reg : '0)
                             + (b_bits_reg[0] ? b_mul_reg : '0);

    // Index reduction step: one index bit per cycle, MSB first
    assign mod_trial = {slot_reg, idx_sh_reg[IDX_W-1]};
    assign mod_next  = (mod_trial >= (AW+1)'(NUM_BINS))
                     ? AW'(mod_trial - (AW+1)'(NUM_BINS)) : AW'(mod_trial);

    // Scale and saturate
    assign p_sh  = acc_reg >> shift_reg;
    assign p_ext = EXT_W'(p_sh);
    assign p_sat = (p_ext > EXT_W'(PWR_MAX)) ? PWR_MAX : p_ext[PWR_W-1:0];

    assign diff_mag = (p_reg < old_reg) ? (old_reg - p_reg) : (p_reg - old_reg);

    // Restoring divider step
    assign div_trial = {rem_reg, q_reg[PWR_W-1]};
    assign div_bit   = (div_trial >= {1'b0, frame_count_reg});

    // Store write port: clearing pass or item update
    assign mem_we    = (state_reg == ST_CLEAR) || out_load;
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : slot_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : nv_reg;

    // Control next state
    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        cnt_next         = cnt_reg;
        frame_count_next = frame_count_reg;
        peak_hold_next   = peak_hold_reg;
        shift_next       = shift_reg;
        out_valid_next   = out_valid_reg;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PEAK_HOLD:   peak_hold_next = cfg_data[0];
                REG_SCALE_SHIFT: shift_next     = cfg_data[SHIFT_W-1:0];
                default:         ;
            endcase
        end

        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(NUM_BINS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_accept)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_CYC - 1))
                    state_next = ST_READ;
            end
            ST_READ:
                state_next = ST_CALC;
            ST_CALC:
            begin
                cnt_next = '0;
                if (frame_count_reg > FRAME_W'(1) && !peak_hold_reg)
                    state_next = ST_DIV;
                else
                    state_next = ST_WRITE;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(PWR_W - 1))
                    state_next = ST_APPLY;
            end
            ST_APPLY:
                state_next = ST_WRITE;
            ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                    if (last_reg && frame_count_reg != FRAME_MAX)
                        frame_count_next = frame_count_reg + 1'b1;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            cnt_reg         <= '0;
            frame_count_reg <= FRAME_W'(1);
            peak_hold_reg   <= 1'b0;
            shift_reg       <= SHIFT_RST;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            cnt_reg         <= cnt_next;
            frame_count_reg <= frame_count_next;
            peak_hold_reg   <= peak_hold_next;
            shift_reg       <= shift_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    a_bits_reg <= mag_re;
                    b_bits_reg <= mag_im;
                    a_mul_reg  <= PW'(mag_re);
                    b_mul_reg  <= PW'(mag_im);
                    acc_reg    <= '0;
                    idx_sh_reg <= bin_index;
                    index_reg  <= bin_index;
                    last_reg   <= last_bin;
                    slot_reg   <= '0;
                end
            end
            ST_MUL:
            begin
                acc_reg    <= acc_sum;
                a_bits_reg <= a_bits_reg >> 1;
                b_bits_reg <= b_bits_reg >> 1;
                a_mul_reg  <= a_mul_reg << 1;
                b_mul_reg  <= b_mul_reg << 1;
                if (cnt_reg < CNT_W'(IDX_W))
                begin
                    slot_reg   <= mod_next;
                    idx_sh_reg <= idx_sh_reg << 1;
                end
            end
            ST_READ:
                p_reg <= p_sat;
            ST_CALC:
            begin
                neg_reg <= (p_reg < old_reg);
                q_reg   <= diff_mag;
                rem_reg <= '0;
                if (frame_count_reg <= FRAME_W'(1))
                    nv_reg <= p_reg;
                else
                    nv_reg <= (p_reg > old_reg) ? p_reg : old_reg;
            end
            ST_DIV:
            begin
                rem_reg <= div_bit ? FRAME_W'(div_trial - {1'b0, frame_count_reg})
                                   : FRAME_W'(div_trial);
                q_reg   <= {q_reg[PWR_W-2:0], div_bit};
            end
            ST_APPLY:
                nv_reg <= neg_reg ? (old_reg - q_reg) : (old_reg + q_reg);
            ST_WRITE:
            begin
                if (out_free)
                begin
                    out_index_reg <= index_reg;
                    out_power_reg <= nv_reg;
                    out_frame_reg <= frame_count_reg;
                    out_last_reg  <= last_reg;
                end
            end
            default:
                ;
        endcase
    end

    // Power store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (state_reg == ST_READ)
            old_reg <= mem[slot_reg];
    end

    assign out_valid    = out_valid_reg;
    assign out_index    = out_index_reg;
    assign avg_power    = out_power_reg;
    assign frame_number = out_frame_reg;
    assign out_last     = out_last_reg;

`ifndef SYNTHESIS
    // Frame count moves only when the last item of a frame is handed out
    a_frame_step: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_count_reg != $past(frame_count_reg))
            |-> $past(state_reg == ST_WRITE && out_free && last_reg))
        else $error("frame count changed outside end of frame");

    // One item in flight: ready drops right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item accepted while busy");

    // Divider step count never reaches PWR_W
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg < CNT_W'(PWR_W)))
        else $error("divider overran its step count");

    // A result is only loaded while the output register is free
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(avg_power)))
        else $error("stalled result overwritten");
`endif

endmodule

### verif/tb.sv
// Testbench for spectrum_power_averager_core: per-bin power, mean and peak hold.
// Depends on spa_pkg and the core RTL. A scoreboard class predicts every result;
// plain tasks drive the bin and register channels; an always block drives the output ready.
module tb;
    import spa_pkg::*;

    localparam int SB           = SAMPLE_BITS_DEF;
    localparam int STALL_LIMIT  = 4000;   // covers the store clearing pass after reset
    localparam int SETTLE_CYCLES = 200;

    // Indexes with no register behind them; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

    localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};
    localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};

    typedef struct {
        logic [IDX_W-1:0]   idx;
        logic [PWR_W-1:0]   power;
        logic [FRAME_W-1:0] frame;
        logic               last;
    } bin_result_t;

    // Predicted power store, frame counter and registers; queue of pending results
    class power_scoreboard;
        logic [PWR_W-1:0]   store [NUM_BINS_DEF];
        logic [FRAME_W-1:0] frame_cnt;
        logic               peak_hold;
        logic [SHIFT_W-1:0] scale_shift;
        bin_result_t        pending_q [$];
        int                 errors;
        int                 results_seen;

        function new();
            foreach (store[i])
                store[i] = '0;
            frame_cnt    = FRAME_W'(1);
            peak_hold    = 1'b0;
            scale_shift  = SHIFT_RST;
            errors       = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            if (index == REG_PEAK_HOLD)
                peak_hold = data[0];
            else if (index == REG_SCALE_SHIFT)
                scale_shift = data[SHIFT_W-1:0];
        endfunction

        // Accepted bin: update the predicted store and queue the result
        function void note_bin(logic signed [SB-1:0] re, logic signed [SB-1:0] im,
                               logic [IDX_W-1:0] idx, logic last);
            longint            s_re, s_im, diff, step;
            longint unsigned   mag_re, mag_im, pwr_full;
            logic [PWR_W-1:0]  pwr, old_val, new_val;
            bin_result_t       r;
            s_re     = re;
            s_im     = im;
            mag_re   = (s_re < 0) ? -s_re : s_re;
            mag_im   = (s_im < 0) ? -s_im : s_im;
            pwr_full = (mag_re * mag_re + mag_im * mag_im) >> scale_shift;
            pwr      = (pwr_full > 64'(PWR_MAX)) ? PWR_MAX : pwr_full[PWR_W-1:0];
            // store depth equals the index range, so the slot is the index
            old_val  = store[idx];
            if (frame_cnt <= FRAME_W'(1))
                new_val = pwr;
            else if (peak_hold)
                new_val = (pwr > old_val) ? pwr : old_val;
            else begin
                // signed difference, divided with truncation toward zero
                diff    = longint'(pwr) - longint'(old_val);
                step    = diff / longint'(frame_cnt);
                new_val = PWR_W'(longint'(old_val) + step);
            end
            store[idx] = new_val;
            r.idx   = idx;
            r.power = new_val;
            r.frame = frame_cnt;
            r.last  = last;
            pending_q.push_back(r);
            if (last && frame_cnt != FRAME_MAX)
                frame_cnt = frame_cnt + 1'b1;
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [IDX_W-1:0] idx, logic [PWR_W-1:0] power,
                                   logic [FRAME_W-1:0] frame, logic last);
            bin_result_t r;
            if (pending_q.size() == 0) begin
                $display("%0t: result with nothing pending: index %0d power %0h frame %0d",
                         $time, idx, power, frame);
                errors++;
                return;
            end
            r = pending_q.pop_front();
            results_seen++;
            compare_field("out_index", r.idx, idx);
            compare_field("avg_power", r.power, power);
            compare_field("frame_number", r.frame, frame);
            compare_field("out_last", r.last, last);
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic signed [SB-1:0]   bin_re = '0;
    logic signed [SB-1:0]   bin_im = '0;
    logic [IDX_W-1:0]       bin_index = '0;
    logic                   last_bin = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [IDX_W-1:0]       out_index;
    logic [PWR_W-1:0]       avg_power;
    logic [FRAME_W-1:0]     frame_number;
    logic                   out_last;

    power_scoreboard sb = new();
    int in_idle_pct  = 0;
    int out_idle_pct = 0;
    int bins_sent    = 0;
    int cfg_writes   = 0;
    int stall_cycles = 0;

    spectrum_power_averager_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .bin_re       (bin_re),
        .bin_im       (bin_im),
        .bin_index    (bin_index),
        .last_bin     (last_bin),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_index    (out_index),
        .avg_power    (avg_power),
        .frame_number (frame_number),
        .out_last     (out_last)
    );

    always #2 clk = ~clk;

    // Result side: check accepted items, then pick the next ready level
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_index, avg_power, frame_number, out_last);
        out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    // Watchdog: too long without any item moving on any channel
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d results pending",
                     $time, STALL_LIMIT, sb.pending_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic signed [SB-1:0] rand_sample();
        case ($urandom_range(6))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2:       return '0;
            3:       return SB'($signed($urandom_range(511)) - 256);
            default: return SB'($urandom);
        endcase
    endfunction

    // One bin; valid stays high from one item to the next unless the sender idles
    task automatic send_bin(input logic signed [SB-1:0] re, input logic signed [SB-1:0] im,
                            input logic [IDX_W-1:0] idx, input logic last);
        if ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < in_idle_pct);
        end
        in_valid  <= 1'b1;
        bin_re    <= re;
        bin_im    <= im;
        bin_index <= idx;
        last_bin  <= last;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_bin(re, im, idx, last);
        bins_sent++;
    endtask

    // Stop sending and wait until every pending result has come back
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_q.size() != 0);
    endtask

    // Register writes happen only with the block idle
    task automatic configure(input logic [CFG_DATA_W-1:0] ph, input logic [CFG_DATA_W-1:0] ss,
                             input bit spare);
        logic [CFG_IDX_W-1:0]  regs [$];
        logic [CFG_DATA_W-1:0] vals [$];
        drain();
        regs.push_back(REG_PEAK_HOLD);
        vals.push_back(ph);
        regs.push_back(REG_SCALE_SHIFT);
        vals.push_back(ss);
        if (spare) begin
            regs.push_back(REG_SPARE_2);
            vals.push_back(CFG_DATA_W'($urandom));
            regs.push_back(REG_SPARE_3);
            vals.push_back(CFG_DATA_W'($urandom));
        end
        foreach (regs[i]) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            sb.write_reg(regs[i], vals[i]);
            cfg_writes++;
        end
        cfg_valid <= 1'b0;
    endtask

    // Frames of random length, with register writes before some; indexes sequential, scattered or repeated
    task automatic random_frames(input int n_items);
        int                    sent;
        int                    len;
        int                    mode;
        logic [IDX_W-1:0]      base;
        logic [IDX_W-1:0]      idx;
        logic [CFG_DATA_W-1:0] ss;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(4) == 0) begin
                case ($urandom_range(5))
                    0:       ss = '0;
                    1:       ss = CFG_DATA_W'(63);
                    2:       ss = CFG_DATA_W'(40);
                    3:       ss = CFG_DATA_W'($urandom);
                    default: ss = CFG_DATA_W'($urandom_range(26, 12));
                endcase
                configure(CFG_DATA_W'($urandom), ss, 1'b0);
            end
            len  = ($urandom_range(9) == 0) ? $urandom_range(160, 33) : $urandom_range(32, 1);
            mode = $urandom_range(3);
            base = IDX_W'($urandom);
            for (int k = 0; k < len; k++) begin
                case (mode)
                    2:       idx = IDX_W'($urandom);
                    3:       idx = base + IDX_W'($urandom_range(3));
                    default: idx = base + IDX_W'(k);
                endcase
                send_bin(rand_sample(), rand_sample(), idx, k == len - 1);
            end
            sent += len;
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        in_idle_pct  = 19;
        out_idle_pct = 51;

        // First frame at reset settings: powers stored as they are
        send_bin(SAMPLE_MIN, SAMPLE_MIN, 10'd0, 1'b0);
        send_bin(SAMPLE_MAX, SAMPLE_MAX, 10'd1023, 1'b0);
        send_bin('0, '0, 10'd512, 1'b0);
        send_bin(24'shAAAAAA, 24'sh555555, 10'h2AA, 1'b0);
        send_bin(24'sh555555, 24'shAAAAAA, 10'h155, 1'b1);

        // Running mean with no shift; unused indexes written too
        configure(8'd0, 8'd0, 1'b1);
        send_bin('0, '0, 10'd0, 1'b0);
        send_bin(SAMPLE_MIN, SAMPLE_MIN, 10'd512, 1'b0);
        send_bin(24'sd3, '0, 10'd1, 1'b0);
        send_bin(-24'sd1, 24'sd1, 10'h2AA, 1'b1);

        // Peak hold, both lower and higher powers
        configure(8'd1, 8'd0, 1'b0);
        send_bin(SAMPLE_MAX, '0, 10'd0, 1'b0);
        send_bin(24'sd1, 24'sd1, 10'd1023, 1'b0);
        send_bin(SAMPLE_MIN, SAMPLE_MIN, 10'd1, 1'b1);

        // Shift beyond range with junk in the upper data bits
        configure(8'hFE, 8'hFF, 1'b0);
        send_bin(SAMPLE_MIN, SAMPLE_MIN, 10'd0, 1'b0);
        send_bin(SAMPLE_MAX, SAMPLE_MIN, 10'd1023, 1'b1);

        configure(8'd1, 8'd40, 1'b0);
        send_bin(SAMPLE_MIN, SAMPLE_MIN, 10'd512, 1'b0);
        send_bin(24'sd1, '0, 10'd3, 1'b1);

        random_frames(350);
        in_idle_pct  = 51;
        out_idle_pct = 19;
        random_frames(350);
        in_idle_pct  = 0;
        out_idle_pct = 0;
        random_frames(350);

        // Short one-bin frames in peak hold, then mean over a few bins
        configure(8'd1, CFG_DATA_W'($urandom_range(30, 10)), 1'b0);
        for (int k = 0; k < 20; k++)
            send_bin(rand_sample(), rand_sample(), IDX_W'($urandom_range(7)), 1'b1);
        configure(8'd0, 8'd12, 1'b0);
        for (int k = 0; k < 40; k++)
            send_bin(rand_sample(), rand_sample(), IDX_W'($urandom_range(7)),
                     1'($urandom_range(1)));

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.pending_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, sb.pending_q.size());
            sb.errors += sb.pending_q.size();
        end

        $display("Run: %0d bins sent, %0d results checked, %0d register writes, %0d errors",
                 bins_sent, sb.results_seen, cfg_writes, sb.errors);
        $display("Mean and peak-hold modes, shifts 0 to 63, frame counter ended at %0d",
                 sb.frame_cnt);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
